// ----- design/ptsb_pkg.sv -----
package ptsb_pkg;

   // Bank dimensions.
   localparam int SLOTS        = 8;
   localparam int COUNT_BITS   = 16;
   localparam int HANDLER_BITS = 8;
   localparam int MAX_RESULTS  = 8;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

   // Fixed widths of the channel fields.
   localparam int KIND_W    = 2;
   localparam int ID_W      = 8;
   localparam int PERIOD_W  = 16;
   localparam int STATUS_W  = 3;
   localparam int SLOTF_W   = 3;
   localparam int HANDLEF_W = 8;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_FIRED      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CANCELLED  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } ptsb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ptsb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic can_step;
      logic last_slot;
      logic can_finish;
   } ptsb_stat_type;

   // Field conversions between channel widths and internal widths.
   function automatic logic [HANDLER_BITS-1:0] id_from_field(logic [ID_W-1:0] f);
      logic [31:0] w;
      w = 32'(f);
      return w[HANDLER_BITS-1:0];
   endfunction

   function automatic logic [HANDLEF_W-1:0] handler_to_field(logic [HANDLER_BITS-1:0] h);
      logic [31:0] w;
      w = 32'(h);
      return w[HANDLEF_W-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] period_from_field(logic [PERIOD_W-1:0] f);
      logic [31:0] w;
      w = 32'(f);
      return w[COUNT_BITS-1:0];
   endfunction

   function automatic logic [SLOTF_W-1:0] slot_to_field(logic [SLOT_W-1:0] s);
      logic [31:0] w;
      w = 32'(s);
      return w[SLOTF_W-1:0];
   endfunction

endpackage

// ----- design/ptsb_req_if.sv -----
interface ptsb_req_if
   import ptsb_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     handler_id;
   logic [PERIOD_W-1:0] period;

   modport source (output valid, kind, handler_id, period, input ready);
   modport sink   (input valid, kind, handler_id, period, output ready);
endinterface

// ----- design/ptsb_rsp_if.sv -----
interface ptsb_rsp_if
   import ptsb_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SLOTF_W-1:0]   slot;
   logic [HANDLEF_W-1:0] fired_handler;
   logic                 last;

   modport source (output valid, status, slot, fired_handler, last, input ready);
   modport sink   (input valid, status, slot, fired_handler, last, output ready);
endinterface

// ----- design/ptsb_ctrl.sv -----
module ptsb_ctrl
   import ptsb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ptsb_stat_type stat,
   output ptsb_cmd_type  cmd
);

   ptsb_state_type state_ff;
   ptsb_state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (stat.can_step && stat.last_slot) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.can_finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WALK: begin
            cmd.step = stat.can_step;
         end
         ST_DONE: begin
            cmd.finish = stat.can_finish;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ptsb_dp.sv -----
module ptsb_dp
   import ptsb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ptsb_cmd_type        cmd,
   output ptsb_stat_type       stat,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ID_W-1:0]     req_handler_id,
   input  logic [PERIOD_W-1:0] req_period,
   ptsb_rsp_if.source          rsp
);

   // Slot bank.
   logic [HANDLER_BITS-1:0] handler_ff [SLOTS];
   logic [HANDLER_BITS-1:0] handler_in [SLOTS];
   logic [COUNT_BITS-1:0]   count_ff   [SLOTS];
   logic [COUNT_BITS-1:0]   count_in   [SLOTS];
   logic [COUNT_BITS-1:0]   reload_ff  [SLOTS];
   logic [COUNT_BITS-1:0]   reload_in  [SLOTS];

   // Current item.
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [HANDLER_BITS-1:0] id_ff, id_in;
   logic [COUNT_BITS-1:0]   period_ff, period_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;

   // Scan results for register and cancel.
   logic              match_found_ff, match_found_in;
   logic [SLOT_W-1:0] match_slot_ff, match_slot_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;

   // Fire held back until it is known whether another follows.
   logic                    pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [HANDLER_BITS-1:0] pend_handler_ff, pend_handler_in;
   logic [FCNT_W-1:0]       fire_cnt_ff, fire_cnt_in;

   // Output register.
   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [SLOT_W-1:0]       out_slot_ff, out_slot_in;
   logic [HANDLER_BITS-1:0] out_handler_ff, out_handler_in;
   logic                    out_last_ff, out_last_in;

   logic                    is_tick;
   logic [HANDLER_BITS-1:0] cur_handler;
   logic [COUNT_BITS-1:0]   cur_count;
   logic [COUNT_BITS-1:0]   cur_reload;
   logic [COUNT_BITS-1:0]   cur_dec;
   logic                    fire;
   logic                    report;
   logic                    step_push;
   logic                    out_free;

   logic                    fin_valid;
   logic [STATUS_W-1:0]     fin_status;
   logic [SLOT_W-1:0]       fin_slot;
   logic [HANDLER_BITS-1:0] fin_handler;

   // Slot under the walk index.
   assign is_tick     = (kind_ff == KIND_TICK);
   assign cur_handler = handler_ff[idx_ff];
   assign cur_count   = count_ff[idx_ff];
   assign cur_reload  = reload_ff[idx_ff];
   assign cur_dec     = cur_count - COUNT_BITS'(1);
   assign fire        = is_tick && (cur_count != '0) && (cur_dec == '0) &&
                        (cur_handler != '0);
   assign report      = fire && (fire_cnt_ff < FCNT_W'(MAX_RESULTS));
   assign step_push   = report && pend_valid_ff;
   assign out_free    = !out_valid_ff || rsp.ready;

   // Final result of the item.
   always_comb begin
      fin_valid   = 1'b0;
      fin_status  = STATUS_IGNORED;
      fin_slot    = '0;
      fin_handler = id_ff;
      unique case (kind_ff)
         KIND_TICK: begin
            fin_valid   = pend_valid_ff;
            fin_status  = STATUS_FIRED;
            fin_slot    = pend_slot_ff;
            fin_handler = pend_handler_ff;
         end
         KIND_REGISTER: begin
            fin_valid = 1'b1;
            priority if (id_ff == '0) begin
               fin_status  = STATUS_IGNORED;
               fin_handler = '0;
            end else if (match_found_ff) begin
               fin_status = STATUS_IGNORED;
               fin_slot   = match_slot_ff;
            end else if (free_found_ff) begin
               fin_status = STATUS_REGISTERED;
               fin_slot   = free_slot_ff;
            end else begin
               fin_status = STATUS_FULL;
            end
         end
         KIND_CANCEL: begin
            fin_valid = 1'b1;
            if ((id_ff != '0) && match_found_ff) begin
               fin_status = STATUS_CANCELLED;
               fin_slot   = match_slot_ff;
            end else begin
               fin_status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            fin_valid = 1'b0;
         end
      endcase
   end

   // Status toward the controller.
   always_comb begin
      stat.can_step   = !step_push || out_free;
      stat.last_slot  = is_tick ? (idx_ff == '0) : (idx_ff == SLOT_W'(SLOTS - 1));
      stat.can_finish = !fin_valid || out_free;
   end

   // Next values of the whole datapath.
   always_comb begin
      handler_in      = handler_ff;
      count_in        = count_ff;
      reload_in       = reload_ff;
      kind_in         = kind_ff;
      id_in           = id_ff;
      period_in       = period_ff;
      idx_in          = idx_ff;
      match_found_in  = match_found_ff;
      match_slot_in   = match_slot_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_handler_in = pend_handler_ff;
      fire_cnt_in     = fire_cnt_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_status_in   = out_status_ff;
      out_slot_in     = out_slot_ff;
      out_handler_in  = out_handler_ff;
      out_last_in     = out_last_ff;

      // Capture a new item; ticks walk from the top slot down.
      if (cmd.load) begin
         kind_in        = req_kind;
         id_in          = id_from_field(req_handler_id);
         period_in      = period_from_field(req_period);
         idx_in         = (req_kind == KIND_TICK) ? SLOT_W'(SLOTS - 1) : '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         pend_valid_in  = 1'b0;
         fire_cnt_in    = '0;
      end

      // One slot per step.
      if (cmd.step) begin
         if (is_tick) begin
            if (cur_count != '0) begin
               count_in[idx_ff] = fire ? cur_reload : cur_dec;
            end
            if (report) begin
               if (pend_valid_ff) begin
                  out_valid_in   = 1'b1;
                  out_status_in  = STATUS_FIRED;
                  out_slot_in    = pend_slot_ff;
                  out_handler_in = pend_handler_ff;
                  out_last_in    = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_slot_in    = idx_ff;
               pend_handler_in = cur_handler;
               fire_cnt_in     = fire_cnt_ff + FCNT_W'(1);
            end
            idx_in = idx_ff - SLOT_W'(1);
         end else begin
            if (!match_found_ff && (cur_handler == id_ff)) begin
               match_found_in = 1'b1;
               match_slot_in  = idx_ff;
            end
            if (!free_found_ff && (cur_handler == '0)) begin
               free_found_in = 1'b1;
               free_slot_in  = idx_ff;
            end
            idx_in = idx_ff + SLOT_W'(1);
         end
      end

      // Commit the item and deliver its final result.
      if (cmd.finish) begin
         if ((kind_ff == KIND_REGISTER) && (id_ff != '0) && !match_found_ff &&
             free_found_ff) begin
            handler_in[free_slot_ff] = id_ff;
            count_in[free_slot_ff]   = period_ff;
            reload_in[free_slot_ff]  = period_ff;
         end
         if ((kind_ff == KIND_CANCEL) && (id_ff != '0) && match_found_ff) begin
            handler_in[match_slot_ff] = '0;
         end
         if (fin_valid) begin
            out_valid_in   = 1'b1;
            out_status_in  = fin_status;
            out_slot_in    = fin_slot;
            out_handler_in = fin_handler;
            out_last_in    = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            handler_ff[i] <= '0;
            count_ff[i]   <= '0;
            reload_ff[i]  <= '0;
         end
         kind_ff        <= KIND_TICK;
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         pend_valid_ff  <= 1'b0;
         fire_cnt_ff    <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         handler_ff     <= handler_in;
         count_ff       <= count_in;
         reload_ff      <= reload_in;
         kind_ff        <= kind_in;
         idx_ff         <= idx_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         pend_valid_ff  <= pend_valid_in;
         fire_cnt_ff    <= fire_cnt_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      id_ff           <= id_in;
      period_ff       <= period_in;
      match_slot_ff   <= match_slot_in;
      free_slot_ff    <= free_slot_in;
      pend_slot_ff    <= pend_slot_in;
      pend_handler_ff <= pend_handler_in;
      out_status_ff   <= out_status_in;
      out_slot_ff     <= out_slot_in;
      out_handler_ff  <= out_handler_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.status        = out_status_ff;
   assign rsp.slot          = slot_to_field(out_slot_ff);
   assign rsp.fired_handler = handler_to_field(out_handler_ff);
   assign rsp.last          = out_last_ff;

endmodule

// ----- design/periodic_timer_slot_bank.sv -----
// Periodic timer slot bank.
// The request channel carries one item per transfer: a tick, a handler
// registration (handler id and reload period) or a handler cancellation.
// The response channel carries the results of an item, one per transfer;
// the final result of each item has last set. A tick gives one fired result
// per slot that expires, highest slot first, and no result if none expires.
// Register and cancel always give exactly one result.
// Each item walks the slot bank one slot per cycle unless the receiver
// stalls the walk: the block takes the item, walks all SLOTS slots and
// commits it, taking no new item before the commit. Its final result is in
// the output register the cycle after the commit. The request side is ready
// again as soon as the item is committed, even while the last result still
// waits in the output register.
// When the receiver stalls, the walk pauses at the slot whose fire would
// need the occupied output register, and no state is lost.
// Synchronous reset frees every slot, clears all counters and reloads and
// empties the output register; the block takes items in the next cycle.
module periodic_timer_slot_bank
   import ptsb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   ptsb_req_if.sink    req_chan,
   ptsb_rsp_if.source  rsp_chan
);

   ptsb_cmd_type  cmd;
   ptsb_stat_type stat;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   ptsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptsb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_chan.kind),
      .req_handler_id (req_chan.handler_id),
      .req_period     (req_chan.period),
      .rsp            (rsp_chan)
   );

endmodule
